>>> rtl/core/thms_pkg.sv
// Shared constants, types and palette lookup for the tile-map height shader.
package thms_pkg;

    // Terrain store geometry
    localparam int MAP_TILES = 65536;
    localparam int ADDR_W    = $clog2(MAP_TILES);
    localparam int ENTRY_W   = 11;
    localparam int BIOME_W   = 3;
    localparam int HEIGHT_W  = 8;

    // Field widths
    localparam int IDX_W      = 16;
    localparam int PIX_W      = 12;
    localparam int MAPDIM_W   = 9;
    localparam int FBDIM_W    = 13;
    localparam int CAM_W      = 12;
    localparam int MAPPOS_W   = PIX_W + 1;
    localparam int MIDX_W     = 2 * MAPDIM_W + 1;
    localparam int FB_ADDR_W  = 24;
    localparam int FB_FULL_W  = PIX_W + FBDIM_W;
    localparam int COLOR_W    = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y      = 3'd5;

    // Register reset values
    localparam logic [MAPDIM_W-1:0] RST_MAP_WIDTH  = 9'd256;
    localparam logic [MAPDIM_W-1:0] RST_MAP_HEIGHT = 9'd256;
    localparam logic [FBDIM_W-1:0]  RST_FB_WIDTH   = 13'd640;
    localparam logic [FBDIM_W-1:0]  RST_FB_HEIGHT  = 13'd480;
    localparam logic [CAM_W-1:0]    RST_CAM        = 12'd0;

    // Item function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    // Colors
    localparam logic [COLOR_W-1:0] COLOR_BLACK  = 32'h000000FF;
    localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;

    // Biome codes
    localparam logic [BIOME_W-1:0] BIOME_WATER    = 3'd0;
    localparam logic [BIOME_W-1:0] BIOME_PLAINS   = 3'd1;
    localparam logic [BIOME_W-1:0] BIOME_FOREST   = 3'd2;
    localparam logic [BIOME_W-1:0] BIOME_MOUNTAIN = 3'd3;
    localparam logic [BIOME_W-1:0] BIOME_SNOW     = 3'd4;

    typedef struct packed {
        logic [MAPDIM_W-1:0] map_width;
        logic [MAPDIM_W-1:0] map_height;
        logic [FBDIM_W-1:0]  fb_width;
        logic [FBDIM_W-1:0]  fb_height;
        logic [CAM_W-1:0]    cam_x;
        logic [CAM_W-1:0]    cam_y;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [ENTRY_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_ram_rd;

    // Render item leaving the address stage alongside its store read
    typedef struct packed {
        logic                 valid;
        logic [FB_ADDR_W-1:0] fb_addr;
        logic                 in_map;
        logic                 in_store;
    } t_stage_bus;

    // Base color of a biome; undefined codes are black
    function automatic logic [COLOR_W-1:0] biome_color(input logic [BIOME_W-1:0] biome);
        logic [COLOR_W-1:0] c;
        unique case (biome)
            BIOME_WATER:    c = 32'h004488FF;
            BIOME_PLAINS:   c = 32'h44AA22FF;
            BIOME_FOREST:   c = 32'h227711FF;
            BIOME_MOUNTAIN: c = 32'h888888FF;
            BIOME_SNOW:     c = 32'hDDDDDDFF;
            default:        c = COLOR_BLACK;
        endcase
        return c;
    endfunction

    // Add shade to one channel, clamp at 255
    function automatic logic [7:0] sat_add(input logic [7:0] c, input logic [5:0] s);
        logic [8:0] sum;
        sum = {1'b0, c} + {3'b000, s};
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

endpackage

>>> rtl/core/thms_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
module thms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/thms_addr.sv
// Input stage and address stage: bounds tests, camera offset, store and framebuffer addresses.
module thms_addr
    import thms_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_func,
    input  logic [IDX_W-1:0]    i_tile_index,
    input  logic [BIOME_W-1:0]  i_tile_biome,
    input  logic [HEIGHT_W-1:0] i_tile_height,
    input  logic [PIX_W-1:0]    i_pix_x,
    input  logic [PIX_W-1:0]    i_pix_y,
    input  logic                i_s3_ready,
    output t_ram_wr             o_wr,
    output t_ram_rd             o_rd,
    output t_stage_bus          o_s2
);

    // Stage 1 registers
    logic                r_v1;
    logic                r_func1;
    logic [IDX_W-1:0]    r_idx1;
    logic [BIOME_W-1:0]  r_biome1;
    logic [HEIGHT_W-1:0] r_height1;
    logic [PIX_W-1:0]    r_px1;
    logic [PIX_W-1:0]    r_py1;
    logic                r_hit1;
    logic                r_inmap1;
    logic [MAPDIM_W-1:0] r_tx1;
    logic [MAPDIM_W-1:0] r_ty1;

    // Stage 2 registers
    logic                 r_v2;
    logic [FB_ADDR_W-1:0] r_fb2;
    logic [MIDX_W-1:0]    r_midx2;
    logic                 r_inmap2;

    logic                 w_ready1;
    logic                 w_ready2;
    logic                 n_hit;
    logic                 n_inmap;
    logic [MAPPOS_W-1:0]  n_tx;
    logic [MAPPOS_W-1:0]  n_ty;
    logic [MIDX_W-1:0]    n_midx;
    logic [FB_FULL_W-1:0] n_fb_full;
    logic [31:0]          w_idx_ext;
    logic [31:0]          w_midx_ext;
    logic                 w_idx_ok;

    assign w_ready2   = !r_v2 || i_s3_ready;
    assign w_ready1   = !r_v1 || w_ready2;
    assign o_in_ready = w_ready1;

    // Bounds and camera offset on the incoming pixel
    always_comb begin
        n_hit = ({1'b0, i_pix_x} < i_cfg.fb_width)
             && ({1'b0, i_pix_x} < MAPPOS_W'(i_cfg.map_width))
             && ({1'b0, i_pix_y} < i_cfg.fb_height)
             && ({1'b0, i_pix_y} < MAPPOS_W'(i_cfg.map_height));
        n_tx    = MAPPOS_W'(i_pix_x) + MAPPOS_W'(i_cfg.cam_x);
        n_ty    = MAPPOS_W'(i_pix_y) + MAPPOS_W'(i_cfg.cam_y);
        n_inmap = (n_tx < MAPPOS_W'(i_cfg.map_width)) && (n_ty < MAPPOS_W'(i_cfg.map_height));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_ready1) begin
            r_v1 <= i_in_valid;
        end
        if (i_in_valid && w_ready1) begin
            r_func1   <= i_func;
            r_idx1    <= i_tile_index;
            r_biome1  <= i_tile_biome;
            r_height1 <= i_tile_height;
            r_px1     <= i_pix_x;
            r_py1     <= i_pix_y;
            r_hit1    <= n_hit;
            r_inmap1  <= n_inmap;
            r_tx1     <= n_tx[MAPDIM_W-1:0];
            r_ty1     <= n_ty[MAPDIM_W-1:0];
        end
    end

    // Store index and framebuffer address; in-map coordinates fit in 9 bits
    always_comb begin
        n_midx    = MIDX_W'(r_ty1) * MIDX_W'(i_cfg.map_width) + MIDX_W'(r_tx1);
        n_fb_full = FB_FULL_W'(r_py1) * FB_FULL_W'(i_cfg.fb_width) + FB_FULL_W'(r_px1);
    end

    // Loads and misses leave stage 1 without entering stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_ready2) begin
            r_v2 <= r_v1 && (r_func1 == FUNC_RENDER) && r_hit1;
        end
        if (r_v1 && w_ready2) begin
            r_fb2    <= n_fb_full[FB_ADDR_W-1:0];
            r_midx2  <= n_midx;
            r_inmap2 <= r_inmap1;
        end
    end

    // Load write goes out as the load leaves stage 1, after any earlier read
    assign w_idx_ext = 32'(r_idx1);
    assign w_idx_ok  = w_idx_ext < 32'(MAP_TILES);
    always_comb begin
        o_wr.en   = r_v1 && (r_func1 == FUNC_LOAD) && w_ready2 && w_idx_ok;
        o_wr.addr = w_idx_ext[ADDR_W-1:0];
        o_wr.data = {r_biome1, r_height1};
    end

    // Store read as the render moves into stage 3
    assign w_midx_ext = 32'(r_midx2);
    always_comb begin
        o_rd.en       = r_v2 && i_s3_ready;
        o_rd.addr     = w_midx_ext[ADDR_W-1:0];
        o_s2.valid    = r_v2;
        o_s2.fb_addr  = r_fb2;
        o_s2.in_map   = r_inmap2;
        o_s2.in_store = w_midx_ext < 32'(MAP_TILES);
    end

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && (r_func1 == FUNC_LOAD) && w_ready2 |=> !r_v2)
        else $error("load item entered the address stage");

    a_miss_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !r_hit1 && w_ready2 |=> !r_v2)
        else $error("out-of-bounds pixel entered the address stage");

endmodule

>>> rtl/core/thms_shade.sv
// Store data stage and output register: palette lookup and height shading.
module thms_shade
    import thms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_stage_bus           i_s2,
    output logic                 o_s3_ready,
    input  logic [ENTRY_W-1:0]   i_rd_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [FB_ADDR_W-1:0] o_fb_address,
    output logic [COLOR_W-1:0]   o_pixel_color
);

    logic                 r_v3;
    logic [FB_ADDR_W-1:0] r_fb3;
    logic                 r_inmap3;
    logic                 r_instore3;
    logic                 r_v4;
    logic [FB_ADDR_W-1:0] r_fb4;
    logic [COLOR_W-1:0]   r_color4;

    logic                 w_ready3;
    logic                 w_ready4;
    logic [ENTRY_W-1:0]   w_entry;
    logic [COLOR_W-1:0]   w_base;
    logic [5:0]           w_shade;
    logic [COLOR_W-1:0]   n_color;

    assign w_ready4   = !r_v4 || i_out_ready;
    assign w_ready3   = !r_v3 || w_ready4;
    assign o_s3_ready = w_ready3;

    // Stage 3 waits beside the RAM read data register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_ready3) begin
            r_v3 <= i_s2.valid;
        end
        if (i_s2.valid && w_ready3) begin
            r_fb3      <= i_s2.fb_addr;
            r_inmap3   <= i_s2.in_map;
            r_instore3 <= i_s2.in_store;
        end
    end

    // Beyond the store reads as a zero entry
    always_comb begin
        w_entry = r_instore3 ? i_rd_data : '0;
        w_base  = biome_color(w_entry[ENTRY_W-1:HEIGHT_W]);
        w_shade = w_entry[HEIGHT_W-1:2];
        if (r_inmap3) begin
            n_color = {sat_add(w_base[31:24], w_shade),
                       sat_add(w_base[23:16], w_shade),
                       sat_add(w_base[15:8],  w_shade),
                       ALPHA_OPAQUE};
        end else begin
            n_color = COLOR_BLACK;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_ready4) begin
            r_v4 <= r_v3;
        end
        if (r_v3 && w_ready4) begin
            r_fb4    <= r_fb3;
            r_color4 <= n_color;
        end
    end

    assign o_out_valid   = r_v4;
    assign o_fb_address  = r_fb4;
    assign o_pixel_color = r_color4;

    a_rd_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !w_ready4 |=> $stable(i_rd_data))
        else $error("store read data changed under a stalled item");

    a_s3_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && w_ready4 |=> r_v4)
        else $error("item lost between data stage and output register");

endmodule

>>> rtl/core/tile_map_height_shader_unit.sv
// Top level of the tile-map height shader: configuration registers, stages and terrain store.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+-----------------------------------------
//  in       | input     | i_in_valid / o_in_ready | func, tile_index/biome/height, pix_x/y
//  out      | output    | o_out_valid/i_out_ready | fb_address, pixel_color
//  cfg      | input     | i_cfg_we (no wait)      | i_cfg_addr, i_cfg_data
//
// One item per cycle sustained while the output is ready; each in-bounds render uses the store read
// port once, each load the write port once. A render passes stages 1 to 3 and the output register.
// Reset clears pipeline valids and the registers; the store is not cleared and holds
// garbage until loaded. A stalled output fills the bubbles first, then holds the input.
module tile_map_height_shader_unit
    import thms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [IDX_W-1:0]      i_tile_index,
    input  logic [BIOME_W-1:0]    i_tile_biome,
    input  logic [HEIGHT_W-1:0]   i_tile_height,
    input  logic [PIX_W-1:0]      i_pix_x,
    input  logic [PIX_W-1:0]      i_pix_y,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [FB_ADDR_W-1:0]  o_fb_address,
    output logic [COLOR_W-1:0]    o_pixel_color
);

    t_cfg             r_cfg;
    t_ram_wr          w_wr;
    t_ram_rd          w_rd;
    t_stage_bus       w_s2;
    logic             w_s3_ready;
    logic [ENTRY_W-1:0] w_rd_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_width  <= RST_MAP_WIDTH;
            r_cfg.map_height <= RST_MAP_HEIGHT;
            r_cfg.fb_width   <= RST_FB_WIDTH;
            r_cfg.fb_height  <= RST_FB_HEIGHT;
            r_cfg.cam_x      <= RST_CAM;
            r_cfg.cam_y      <= RST_CAM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_MAP_WIDTH:  r_cfg.map_width  <= i_cfg_data[MAPDIM_W-1:0];
                CFG_MAP_HEIGHT: r_cfg.map_height <= i_cfg_data[MAPDIM_W-1:0];
                CFG_FB_WIDTH:   r_cfg.fb_width   <= i_cfg_data[FBDIM_W-1:0];
                CFG_FB_HEIGHT:  r_cfg.fb_height  <= i_cfg_data[FBDIM_W-1:0];
                CFG_CAM_X:      r_cfg.cam_x      <= i_cfg_data[CAM_W-1:0];
                CFG_CAM_Y:      r_cfg.cam_y      <= i_cfg_data[CAM_W-1:0];
                default:        ;
            endcase
        end
    end

    thms_addr u_addr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_tile_index  (i_tile_index),
        .i_tile_biome  (i_tile_biome),
        .i_tile_height (i_tile_height),
        .i_pix_x       (i_pix_x),
        .i_pix_y       (i_pix_y),
        .i_s3_ready    (w_s3_ready),
        .o_wr          (w_wr),
        .o_rd          (w_rd),
        .o_s2          (w_s2)
    );

    // Terrain store: biome in the top three bits, height below
    thms_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAP_TILES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_wr.en),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_re    (w_rd.en),
        .i_raddr (w_rd.addr),
        .o_rdata (w_rd_data)
    );

    thms_shade u_shade (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s2          (w_s2),
        .o_s3_ready    (w_s3_ready),
        .i_rd_data     (w_rd_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_fb_address  (o_fb_address),
        .o_pixel_color (o_pixel_color)
    );

    a_empty_takes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input held off with an empty output register");

endmodule
